>>> src/shp_pkg.sv
// Package for the SHA-256 hash chain byte generator.
// Round constants, initial hash words, command and register codes, core command type.
// No dependencies.
`default_nettype none
package shp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DigWords = 8;

  // request / reseed command codes
  localparam logic CmdRequest = 1'b0;
  localparam logic CmdReseed  = 1'b1;

  // configuration register indexes
  localparam logic CfgSeed    = 1'b0;
  localparam logic CfgEntropy = 1'b1;

  localparam logic [31:0] EntropyMask = 32'h7FFF_FFFF;
  localparam logic [31:0] PadWord     = 32'h8000_0000;
  localparam logic [31:0] LenSeed     = 32'd64;   // 8-byte message, in bits
  localparam logic [31:0] LenDigest   = 32'd256;  // 32-byte message, in bits

  localparam logic [31:0] IvTab [DigWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // control from the sequencer to the compression core
  typedef struct packed {
    logic        load;   // shift one message word in
    logic [31:0] word;
    logic        start;  // begin 64 rounds
  } shp_core_cmd_t;

endpackage
`default_nettype wire

>>> src/shp_if.sv
// Valid/ready channel interfaces for request beats and byte beats.
// Depends on nothing.
`default_nettype none
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [5:0] byte_count;
  modport source (output valid, command, byte_count, input ready);
  modport sink   (input valid, command, byte_count, output ready);
endinterface

interface shp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rand_byte;
  logic       last_byte;
  modport source (output valid, rand_byte, last_byte, input ready);
  modport sink   (input valid, rand_byte, last_byte, output ready);
endinterface
`default_nettype wire

>>> src/shp_core.sv
// Iterative SHA-256 compression core, one round per cycle, single block.
// Depends on shp_pkg.
`default_nettype none
module shp_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire shp_pkg::shp_core_cmd_t cmd_i,
  input  wire logic [2:0]             rd_idx_i,
  output logic                        done_o,
  output logic [31:0]                 rd_word_o
);
  import shp_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic        busy_q;
  logic        done_q;

  logic [31:0] t1, t2, s0w, s1w, wnew;

  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + KTab[rnd_q] + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    s0w = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1w = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0w + w_q[9] + s1w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        rnd_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= IvTab[i];
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end else if (cmd_i.load) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= cmd_i.word;
    end
  end

  assign done_o    = done_q;
  assign rd_word_o = IvTab[rd_idx_i] + v_q[rd_idx_i];

endmodule
`default_nettype wire

>>> src/sha256_hash_chain_prng.sv
// SHA-256 hash chain byte generator, top level. Depends on shp_pkg, shp_if, shp_core.
// A byte from a fresh digest is first read from the digest RAM, then offered. One hash pass
// loads 16 message words, starts the core, runs 64 rounds, writes 8 words back; a refill is one pass.
// A reseed (or the automatic first seeding) is one more pass; its digest is not emitted.
// Throughput: one request at a time; the next byte's RAM read starts only after the last byte is taken.
// Reset: digest RAM is never read before written; position starts exhausted, not seeded.
`default_nettype none
module sha256_hash_chain_prng #(
  parameter int unsigned MAX_REQUEST_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  shp_in_if.sink           in_i,
  shp_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);
  import shp_pkg::*;

  localparam int unsigned RemW = $clog2(MAX_REQUEST_BYTES + 1);
  localparam logic [6:0]  MaxReq = 7'(MAX_REQUEST_BYTES);

  typedef enum logic [2:0] {
    StIdle, StLoad, StStart, StComp, StWrbk, StEmitChk, StEmitOut
  } state_e;

  // what the current compression is for
  typedef enum logic [1:0] {
    ModeReseed,      // reseed command, no bytes follow
    ModeReseedEmit,  // auto seeding on first request, bytes follow
    ModeAdvance      // next digest of the chain
  } mode_e;

  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  state_e          state_q;
  mode_e           mode_q;
  logic [4:0]      lc_q;       // load counter, word lc-1 is shifted in
  logic [2:0]      wc_q;       // write-back word
  logic [5:0]      pos_q;      // next unused digest byte, 32 = exhausted
  logic [RemW-1:0] rem_q;      // bytes left in this request
  logic            seeded_q;
  logic [63:0]     seed_q;     // seed for the pending reseed
  logic [63:0]     cfg_seed_q;
  logic [31:0]     cfg_ent_q;

  // digest RAM: 8 words, word i = H[i]
  logic [31:0] mem [DigWords];
  logic [31:0] rdata_q;
  logic        mem_re, mem_we;
  logic [2:0]  mem_raddr;

  shp_core_cmd_t core_cmd;
  logic          core_done;
  logic [31:0]   core_word;
  logic [3:0]    blk_idx;
  logic [31:0]   blk_word;
  logic [6:0]    req_cnt;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_seed_q <= '0;
      cfg_ent_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSeed:    cfg_seed_q <= cfg_data_i;
        CfgEntropy: cfg_ent_q  <= cfg_data_i[31:0];
        default:    ;
      endcase
    end
  end

  // ---------------- digest RAM ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wc_q] <= core_word;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // RAM reads: message words during a chain advance, one byte word while emitting.
  // Writes happen only in write-back, so the sequencer itself keeps reads and writes apart.
  always_comb begin
    mem_we    = (state_q == StWrbk);
    mem_re    = 1'b0;
    mem_raddr = pos_q[4:2];
    if (state_q == StLoad) begin
      mem_raddr = lc_q[2:0];
      mem_re    = (mode_q == ModeAdvance) && (lc_q < 5'd8);
    end else if (state_q == StEmitChk) begin
      mem_re = (pos_q != 6'd32);
    end
  end

  // ---------------- message block words ----------------
  // Reseed: 8 seed bytes LSB first, pad, length 64 bits.
  // Advance: 8 digest words, pad, length 256 bits.
  always_comb begin
    blk_idx  = 4'(lc_q - 5'd1);
    blk_word = '0;
    if (mode_q == ModeAdvance) begin
      if (blk_idx < 4'd8)        blk_word = rdata_q;
      else if (blk_idx == 4'd8)  blk_word = PadWord;
      else if (blk_idx == 4'd15) blk_word = LenDigest;
    end else begin
      if (blk_idx == 4'd0)       blk_word = bswap(seed_q[31:0]);
      else if (blk_idx == 4'd1)  blk_word = bswap(seed_q[63:32]);
      else if (blk_idx == 4'd2)  blk_word = PadWord;
      else if (blk_idx == 4'd15) blk_word = LenSeed;
    end
  end

  assign core_cmd.load  = (state_q == StLoad) && (lc_q != 5'd0);
  assign core_cmd.word  = blk_word;
  assign core_cmd.start = (state_q == StStart);

  shp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (core_cmd),
    .rd_idx_i  (wc_q),
    .done_o    (core_done),
    .rd_word_o (core_word)
  );

  // ---------------- handshakes ----------------
  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = (state_q == StEmitOut);
  assign out_o.last_byte = (rem_q == RemW'(1));
  always_comb begin
    case (pos_q[1:0])
      2'd0:    out_o.rand_byte = rdata_q[31:24];
      2'd1:    out_o.rand_byte = rdata_q[23:16];
      2'd2:    out_o.rand_byte = rdata_q[15:8];
      default: out_o.rand_byte = rdata_q[7:0];
    endcase
  end

  // oversized requests saturate
  assign req_cnt = ({1'b0, in_i.byte_count} > MaxReq) ? MaxReq : {1'b0, in_i.byte_count};

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mode_q   <= ModeReseed;
      lc_q     <= '0;
      wc_q     <= '0;
      pos_q    <= 6'd32;
      rem_q    <= '0;
      seeded_q <= 1'b0;
      seed_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            lc_q <= '0;
            if (in_i.command == CmdReseed) begin
              // zero seed falls back to the masked entropy word
              seed_q <= (cfg_seed_q != 64'd0) ? cfg_seed_q
                                               : {32'd0, cfg_ent_q & EntropyMask};
              mode_q  <= ModeReseed;
              state_q <= StLoad;
            end else if (req_cnt != 7'd0) begin
              rem_q <= RemW'(req_cnt);
              if (!seeded_q) begin
                // first request: seed from the raw entropy word
                seed_q  <= {32'd0, cfg_ent_q};
                mode_q  <= ModeReseedEmit;
                state_q <= StLoad;
              end else begin
                state_q <= StEmitChk;
              end
            end
          end
        end
        StLoad: begin
          lc_q <= lc_q + 5'd1;
          if (lc_q == 5'd16) state_q <= StStart;
        end
        StStart: state_q <= StComp;
        StComp: begin
          if (core_done) begin
            wc_q    <= '0;
            state_q <= StWrbk;
          end
        end
        StWrbk: begin
          wc_q <= wc_q + 3'd1;
          if (wc_q == 3'd7) begin
            if (mode_q == ModeAdvance) begin
              pos_q   <= 6'd0;
              state_q <= StEmitChk;
            end else begin
              pos_q    <= 6'd32;
              seeded_q <= 1'b1;
              state_q  <= (mode_q == ModeReseed) ? StIdle : StEmitChk;
            end
          end
        end
        StEmitChk: begin
          if (pos_q == 6'd32) begin
            // digest used up: hash it again
            mode_q  <= ModeAdvance;
            lc_q    <= '0;
            state_q <= StLoad;
          end else begin
            state_q <= StEmitOut;
          end
        end
        StEmitOut: begin
          if (out_o.ready) begin
            pos_q <= pos_q + 6'd1;
            rem_q <= rem_q - RemW'(1);
            state_q <= (rem_q == RemW'(1)) ? StIdle : StEmitChk;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the SHA-256 hash chain byte generator.
// Depends on shp_pkg, shp_in_if / shp_out_if and the sha256_hash_chain_prng top level.
`timescale 1ns / 1ps
module tb_top;
  import shp_pkg::*;

  localparam int unsigned MaxBytes  = 32;
  localparam int unsigned SettleCyc = 120;      // covers a reseed or refill
  localparam int unsigned CycLimit  = 4000000;

  typedef struct {
    logic       cmd;
    logic [5:0] cnt;
  } req_beat_t;

  typedef struct {
    logic [7:0] val;
    logic       last;
  } byte_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [63:0] cfg_data_i;

  shp_in_if  in_ch ();
  shp_out_if out_ch ();

  sha256_hash_chain_prng #(.MAX_REQUEST_BYTES(MaxBytes)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // stimulus and expectations
  req_beat_t  pending_reqs[$];
  byte_beat_t expected_bytes[$];

  // predictor state: shadow registers plus chain state
  logic [63:0]  seed_reg;
  logic [31:0]  entropy_reg;
  logic [255:0] chain;       // byte k at [255-8k -: 8]
  int unsigned  chain_pos;
  logic         seeded;

  // bookkeeping
  int unsigned errors, cycles, bytes_checked, n_requests, n_reseeds;
  bit          req_took;
  bit          src_burst, snk_burst;  // phases with no idling on that side
  int unsigned src_gap, snk_gap, long_hold;
  bit          long_hold_done;

  // ---------------------------------------------------------------------------
  // SHA-256 of a short message (at most 32 bytes here, so one block)
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha256_short(input logic [7:0] msg [32], input int len);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] h [8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    logic [15:0] bits;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < len; i++) blk[i] = msg[i];
    blk[len] = 8'h80;
    bits = 16'(len * 8);
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) h[i] = IvTab[i];
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + KTab[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
  endfunction

  // seed is hashed as 8 bytes, LSB first; zero seed falls back to masked entropy
  task automatic chain_reseed(input logic [63:0] seed);
    logic [7:0] msg [32];
    logic [63:0] s;
    s = (seed == 64'd0) ? {32'd0, entropy_reg & EntropyMask} : seed;
    for (int i = 0; i < 32; i++) msg[i] = 8'h00;
    for (int i = 0; i < 8; i++) msg[i] = s[8*i +: 8];
    chain     = sha256_short(msg, 8);
    chain_pos = 32;
    seeded    = 1'b1;
  endtask

  // one accepted request beat -> expected byte beats
  task automatic predict_request(input req_beat_t rq);
    logic [7:0] msg [32];
    int unsigned n;
    if (rq.cmd == CmdReseed) begin
      chain_reseed(seed_reg);
      n_reseeds++;
    end else begin
      n_requests++;
      n = (rq.cnt > MaxBytes) ? MaxBytes : rq.cnt;
      // first nonzero request after reset seeds from the raw entropy word
      if (n != 0 && !seeded) chain_reseed({32'd0, entropy_reg});
      for (int i = 0; i < n; i++) begin
        if (chain_pos >= 32) begin
          for (int k = 0; k < 32; k++) msg[k] = chain[255 - 8*k -: 8];
          chain     = sha256_short(msg, 32);
          chain_pos = 0;
        end
        expected_bytes.push_back('{val: chain[255 - 8*chain_pos -: 8],
                                   last: (i + 1 == n)});
        chain_pos++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("MISMATCH t=%0t %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, time-0 values
  // ---------------------------------------------------------------------------
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CfgSeed;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CmdRequest;
    in_ch.byte_count = '0;
    out_ch.ready     = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit; a hang ends here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("sha256_hash_chain_prng verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side: sample at the rising edge, drive at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_took = in_ch.valid && in_ch.ready;
    if (req_took) predict_request('{cmd: in_ch.command, cnt: in_ch.byte_count});
    // register writes update the shadow copy at the same edge the block sees them
    if (cfg_we_i) begin
      if (cfg_idx_i == CfgSeed) seed_reg = cfg_data_i;
      else                      entropy_reg = cfg_data_i[31:0];
    end
  end

  always @(negedge clk_i) begin
    req_beat_t nx;
    logic      v;
    if (rst_ni && (!in_ch.valid || req_took)) begin
      v = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_reqs.size() > 0) begin
        nx = pending_reqs.pop_front();
        in_ch.command    <= nx.cmd;
        in_ch.byte_count <= nx.cnt;
        v       = 1'b1;
        src_gap = pick_gap(src_burst);
      end
      in_ch.valid <= v;
    end
  end

  // ---------------------------------------------------------------------------
  // byte side: random back-pressure, plus one long hold-off once traffic is flowing
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && bytes_checked >= 600) begin
        long_hold_done = 1'b1;
        long_hold      = 600;   // several requests pile up behind this
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        snk_gap = pick_gap(snk_burst);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    byte_beat_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected rand_byte", out_ch.rand_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_ch.rand_byte !== want.val) report_mismatch("rand_byte", out_ch.rand_byte, want.val);
        if (out_ch.last_byte !== want.last)
          report_mismatch("last_byte", {7'd0, out_ch.last_byte}, {7'd0, want.last});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic push_req(input logic cmd, input logic [5:0] cnt);
    pending_reqs.push_back('{cmd: cmd, cnt: cnt});
  endtask

  // sender stops until every byte is back, then the block gets time to finish a reseed
  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() > 0 || in_ch.valid || expected_bytes.size() > 0);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    int unsigned r;
    errors = 0; cycles = 0; bytes_checked = 0; n_requests = 0; n_reseeds = 0;
    src_gap = 0; snk_gap = 0; long_hold = 0; long_hold_done = 0;
    src_burst = 0; snk_burst = 0;
    seed_reg = '0; entropy_reg = '0; chain = '0; chain_pos = 32; seeded = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // auto-seed takes the full 32-bit entropy word, unmasked
    write_reg(CfgEntropy, 64'hFFFF_FFFF);
    push_req(CmdRequest, 6'd0);    // zero count, must not seed
    push_req(CmdRequest, 6'd1);
    push_req(CmdRequest, 6'd32);   // crosses a digest boundary
    push_req(CmdRequest, 6'd33);   // saturates
    push_req(CmdRequest, 6'd63);
    push_req(CmdRequest, 6'd5);
    push_req(CmdReseed,  6'd63);   // count ignored; zero seed -> masked entropy
    push_req(CmdRequest, 6'd32);
    push_req(CmdRequest, 6'd31);
    push_req(CmdRequest, 6'd2);
    drain();

    write_reg(CfgSeed, '1);
    push_req(CmdReseed,  6'd0);
    push_req(CmdReseed,  6'd21);   // back-to-back reseeds
    push_req(CmdRequest, 6'd20);
    push_req(CmdRequest, 6'd17);
    drain();

    write_reg(CfgSeed, 64'd1);
    write_reg(CfgEntropy, 64'd0);
    push_req(CmdReseed,  6'd0);
    push_req(CmdRequest, 6'd9);
    drain();
    write_reg(CfgSeed, 64'd0);     // zero seed and zero entropy
    push_req(CmdReseed,  6'd0);
    push_req(CmdRequest, 6'd32);
    push_req(CmdRequest, 6'd0);
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgSeed, pick_seed());
      write_reg(CfgEntropy, (ph == 1) ? 64'h8000_0000 : {32'd0, $urandom()});
      src_burst = (ph == 2);
      snk_burst = (ph == 3);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10)      push_req(CmdReseed, 6'($urandom_range(0, 63)));
        else if (r < 18) push_req(CmdRequest, 6'd0);
        else if (r < 28) push_req(CmdRequest, 6'($urandom_range(33, 63)));
        else             push_req(CmdRequest, 6'($urandom_range(1, 32)));
      end
      drain();
    end

    $display("checked %0d bytes from %0d requests and %0d reseeds", bytes_checked,
             n_requests, n_reseeds);
    if (errors == 0) begin
      $display("sha256_hash_chain_prng verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("sha256_hash_chain_prng verification failed");
    end
    $finish;
  end

endmodule
